FILE: rtl/brsq_pkg.sv
// Package for the backlight ramped brightness sequencer.
// Holds the channel payload types, the register map and the controller
// write constants shared by every module of the block.
package brsq_pkg;

    localparam int LevelW  = 10;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 24;
    localparam int TargetW = 24;
    localparam int StepW   = 20;
    localparam int CountW  = 5;
    localparam int TotalW  = StepW + CountW;
    localparam int NumOpt  = 4;
    localparam int MaxWr   = 4;
    localparam int WrCntW  = 3;

    localparam logic [CfgIdxW-1:0] CFG_BLOCK_READY = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RAMP_TARGET = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_STEP_TIME_0 = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_STEP_TIME_1 = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_STEP_TIME_2 = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_STEP_TIME_3 = 3'd5;

    localparam logic [TargetW-1:0] RAMP_TARGET_RST = 24'd1000000;
    localparam logic [StepW-1:0]   STEP_TIME_0_RST = 20'd100;
    localparam logic [StepW-1:0]   STEP_TIME_1_RST = 20'd25000;
    localparam logic [StepW-1:0]   STEP_TIME_2_RST = 20'd50000;
    localparam logic [StepW-1:0]   STEP_TIME_3_RST = 20'd100000;

    localparam logic [7:0] ADDR_ENABLE  = 8'h10;
    localparam logic [7:0] ADDR_OPTIONS = 8'h20;
    localparam logic [7:0] ADDR_BRIGHT  = 8'hA0;
    localparam logic [7:0] ENABLE_ON    = 8'h61;
    localparam logic [7:0] ENABLE_OFF   = 8'h00;
    localparam logic [7:0] LEVEL_MAX    = 8'd255;

    typedef struct packed {
        logic [LevelW-1:0] brightness_level;
        logic              ramp_request;
    } in_t;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       wait_before;
        logic       last_write;
    } out_t;

    typedef struct packed {
        logic                         block_ready;
        logic [TargetW-1:0]           ramp_target_us;
        logic [NumOpt-1:0][StepW-1:0] step_time;
    } cfg_t;

    typedef struct packed {
        logic [7:0]                    level;
        logic                          ramp;
        logic                          need_enable;
        logic [NumOpt-1:0][TotalW-1:0] total;
    } calc_t;

endpackage

FILE: rtl/brsq_cfg.sv
// Configuration register file of the brightness sequencer.
// Decodes writes on the configuration channel; depends on brsq_pkg.
module brsq_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [brsq_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [brsq_pkg::CfgDatW-1:0]  cfg_wdata,
    output brsq_pkg::cfg_t                cfg
);
    import brsq_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_ready    <= 1'b0;
            cfg_reg.ramp_target_us <= RAMP_TARGET_RST;
            cfg_reg.step_time[0]   <= STEP_TIME_0_RST;
            cfg_reg.step_time[1]   <= STEP_TIME_1_RST;
            cfg_reg.step_time[2]   <= STEP_TIME_2_RST;
            cfg_reg.step_time[3]   <= STEP_TIME_3_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLOCK_READY: cfg_reg.block_ready    <= cfg_wdata[0];
                CFG_RAMP_TARGET: cfg_reg.ramp_target_us <= cfg_wdata[TargetW-1:0];
                CFG_STEP_TIME_0: cfg_reg.step_time[0]   <= cfg_wdata[StepW-1:0];
                CFG_STEP_TIME_1: cfg_reg.step_time[1]   <= cfg_wdata[StepW-1:0];
                CFG_STEP_TIME_2: cfg_reg.step_time[2]   <= cfg_wdata[StepW-1:0];
                CFG_STEP_TIME_3: cfg_reg.step_time[3]   <= cfg_wdata[StepW-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/brsq_calc.sv
// Input register and first processing stage of the brightness sequencer.
// Clamps the level, keeps the controller state and forms the ramp totals.
// Depends on brsq_pkg.
module brsq_calc (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  brsq_pkg::in_t   s_data,
    input  brsq_pkg::cfg_t  cfg,
    input  logic            calc_ready,
    output logic            calc_valid,
    output brsq_pkg::calc_t calc
);
    import brsq_pkg::*;

    logic               in_vld_reg;
    in_t                in_reg;
    logic               calc_vld_reg;
    calc_t              calc_reg;
    calc_t              calc_next;
    logic               chip_en_reg;
    logic               chip_en_next;
    logic [7:0]         prev_level_reg;
    logic [7:0]         prev_level_next;
    logic               stage_ready;
    logic               update;
    logic [7:0]         level;
    logic [7:0]         diff;
    logic [CountW-1:0]  steps;

    assign stage_ready = !calc_vld_reg || calc_ready;
    assign s_ready     = !in_vld_reg || stage_ready;
    assign update      = in_vld_reg && stage_ready && cfg.block_ready;
    assign calc_valid  = calc_vld_reg;
    assign calc        = calc_reg;

    always_comb begin
        level = (|in_reg.brightness_level[LevelW-1:8]) ? LEVEL_MAX
                                                        : in_reg.brightness_level[7:0];
        diff  = (prev_level_reg > level) ? (prev_level_reg - level) : (level - prev_level_reg);
        steps = diff[7:3];
        calc_next.level       = level;
        calc_next.ramp        = in_reg.ramp_request;
        calc_next.need_enable = !chip_en_reg;
        for (int i = 0; i < NumOpt; i++) begin
            calc_next.total[i] = TotalW'(steps) * TotalW'(cfg.step_time[i]);
        end
        chip_en_next    = update ? (level != 8'd0) : chip_en_reg;
        prev_level_next = update ? level : prev_level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            calc_vld_reg   <= 1'b0;
            chip_en_reg    <= 1'b0;
            prev_level_reg <= LEVEL_MAX;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (stage_ready) begin
                calc_vld_reg <= in_vld_reg && cfg.block_ready;
            end
            chip_en_reg    <= chip_en_next;
            prev_level_reg <= prev_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (update) begin
            calc_reg <= calc_next;
        end
    end

    a_disable_on_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (update && level == 8'd0) |=> !chip_en_reg)
        else $error("controller not marked off after a zero level");

    a_enable_on_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (update && level != 8'd0) |=> chip_en_reg)
        else $error("controller not marked on after a nonzero level");

endmodule

FILE: rtl/brsq_emit.sv
// Step selection and write burst stage of the brightness sequencer.
// Builds up to four controller writes per request and sends them one a cycle
// while the receiver is ready. Depends on brsq_pkg.
module brsq_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  brsq_pkg::cfg_t  cfg,
    input  logic            calc_valid,
    output logic            calc_ready,
    input  brsq_pkg::calc_t calc,
    output logic            m_valid,
    input  logic            m_ready,
    output brsq_pkg::out_t  m_data
);
    import brsq_pkg::*;

    out_t               ent_reg [MaxWr];
    out_t               ent_next [MaxWr];
    logic [WrCntW-1:0]  cnt_reg;
    logic [WrCntW-1:0]  cnt_next;
    logic [WrCntW-1:0]  load_cnt;
    logic [WrCntW-1:0]  last_pos;
    logic               load;
    logic               take;
    logic [TotalW-1:0]  target;
    logic [NumOpt-1:0]  reach;
    logic [NumOpt-1:0]  prefer_lower;
    logic [1:0]         index;
    out_t               wr_enable;
    out_t               wr_options;
    out_t               wr_bright;
    out_t               wr_disable;

    assign m_valid    = cnt_reg != '0;
    assign m_data     = ent_reg[0];
    assign take       = m_valid && m_ready;
    assign calc_ready = (cnt_reg == '0) || (cnt_reg == WrCntW'(1) && m_ready);
    assign load       = calc_valid && calc_ready;

    always_comb begin
        target = TotalW'(cfg.ramp_target_us);
        for (int i = 0; i < NumOpt; i++) begin
            reach[i] = calc.total[i] >= target;
        end
        prefer_lower[0] = 1'b0;
        for (int i = 1; i < NumOpt; i++) begin
            prefer_lower[i] = (calc.total[i] - target) > (target - calc.total[i-1]);
        end
        if (reach[0]) begin
            index = 2'd0;
        end else if (reach[1]) begin
            index = prefer_lower[1] ? 2'd0 : 2'd1;
        end else if (reach[2]) begin
            index = prefer_lower[2] ? 2'd1 : 2'd2;
        end else if (reach[3]) begin
            index = prefer_lower[3] ? 2'd2 : 2'd3;
        end else begin
            index = 2'd3;
        end

        wr_enable  = '{reg_address: ADDR_ENABLE, reg_data: ENABLE_ON,
                       wait_before: 1'b0, last_write: 1'b0};
        wr_options = '{reg_address: ADDR_OPTIONS,
                       reg_data: calc.ramp ? 8'(index) : 8'd0,
                       wait_before: 1'b0, last_write: 1'b0};
        wr_bright  = '{reg_address: ADDR_BRIGHT, reg_data: 8'(calc.level[7:3]),
                       wait_before: 1'b0, last_write: 1'b0};
        wr_disable = '{reg_address: ADDR_ENABLE, reg_data: ENABLE_OFF,
                       wait_before: calc.ramp, last_write: 1'b0};

        load_cnt = WrCntW'(2) + WrCntW'(calc.need_enable) + WrCntW'(calc.level == 8'd0);
        last_pos = load_cnt - WrCntW'(1);

        for (int i = 0; i < MaxWr; i++) begin
            ent_next[i] = ent_reg[i];
        end
        cnt_next = cnt_reg;
        if (load) begin
            if (calc.need_enable) begin
                ent_next[0] = wr_enable;
                ent_next[1] = wr_options;
                ent_next[2] = wr_bright;
                ent_next[3] = wr_disable;
            end else begin
                ent_next[0] = wr_options;
                ent_next[1] = wr_bright;
                ent_next[2] = wr_disable;
                ent_next[3] = wr_disable;
            end
            for (int i = 0; i < MaxWr; i++) begin
                ent_next[i].last_write = (WrCntW'(i) == last_pos);
            end
            cnt_next = load_cnt;
        end else if (take) begin
            for (int i = 0; i < MaxWr - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
            cnt_next = cnt_reg - WrCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MaxWr; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= WrCntW'(MaxWr))
        else $error("write burst count out of range");

    a_last_marks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_write == (cnt_reg == WrCntW'(1))))
        else $error("last write flag does not match the end of the burst");

    a_wait_only_disable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.wait_before) |->
            (m_data.reg_address == ADDR_ENABLE && m_data.reg_data == ENABLE_OFF))
        else $error("wait flag set on a write other than the disable write");

endmodule

FILE: rtl/backlight_ramped_brightness_sequencer_core.sv
// Top level of the backlight ramped brightness sequencer.
// Instantiates brsq_cfg, brsq_calc and brsq_emit; depends on brsq_pkg.
//
// The s_ channel takes brightness requests, a level and a ramp flag. Each
// request turns into two to four controller register writes on the m_ channel:
// an enable write when the controller is off, the options write with the ramp
// step index, the brightness write, and a disable write for a zero level. The
// last write of a request has last_write set. While block_ready is zero a
// request is taken and dropped without any write.
// Configuration registers are written on the cfg_ channel, which is always
// ready; the user must change them only while no request is in flight, and
// the block itself does not enforce this. A request passes an input
// register, a stage that forms the ramp totals with four narrow multipliers,
// and a burst register before its first write appears. The burst register
// then sends one write a cycle while the receiver is ready, and the writes of
// a new request follow with no gap when it already waits in the stage before.
// When the receiver stalls, the burst holds and the stages behind it fill
// and then stop taking requests.
// Reset turns the controller state off and sets the last level to full scale.
module backlight_ramped_brightness_sequencer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  brsq_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output brsq_pkg::out_t                m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [brsq_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [brsq_pkg::CfgDatW-1:0]  cfg_wdata
);
    import brsq_pkg::*;

    cfg_t  cfg;
    calc_t calc;
    logic  calc_valid;
    logic  calc_ready;

    brsq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    brsq_calc u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg        (cfg),
        .calc_ready (calc_ready),
        .calc_valid (calc_valid),
        .calc       (calc)
    );

    brsq_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .calc_valid (calc_valid),
        .calc_ready (calc_ready),
        .calc       (calc),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: verif/backlight_ramped_brightness_sequencer_core_tb.sv
// Self-checking testbench for backlight_ramped_brightness_sequencer_core.
// Drives brightness requests and register writes, predicts each controller write
// burst in a local model and compares every write; needs brsq_pkg and the core.
module backlight_ramped_brightness_sequencer_core_tb;
    import brsq_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_REQUESTS = 40;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_t                 s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_t                m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDatW-1:0]  cfg_wdata = '0;

    in_t  pending_requests [$];
    out_t expected_writes [$];

    logic               ready_shadow = 1'b0;
    logic [TargetW-1:0] target_shadow = RAMP_TARGET_RST;
    logic [StepW-1:0]   step_shadow [NumOpt] = '{STEP_TIME_0_RST, STEP_TIME_1_RST,
                                                 STEP_TIME_2_RST, STEP_TIME_3_RST};
    logic               chip_on_shadow = 1'b0;
    logic [7:0]         level_shadow = LEVEL_MAX;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  s_taken = 1'b0;
    bit  stall_kick = 1'b0;
    int  stall_left = 0;
    int  cycles = 0;
    int  mismatches = 0;
    int  requests_taken = 0;
    int  requests_dropped = 0;
    int  writes_checked = 0;
    int  config_writes = 0;

    backlight_ramped_brightness_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic [1:0] choose_step_index(logic [4:0] steps);
        longint unsigned goal;
        longint unsigned total;
        longint unsigned shortfall;
        goal = target_shadow;
        for (int i = 0; i < NumOpt; i++) begin
            total = longint'(steps) * longint'(step_shadow[i]);
            if (total >= goal) begin
                if (i > 0) begin
                    shortfall = goal - longint'(steps) * longint'(step_shadow[i-1]);
                    if (total - goal > shortfall) return 2'(i - 1);
                end
                return 2'(i);
            end
        end
        return 2'd3;
    endfunction

    function automatic void predict_writes(in_t req);
        out_t       burst [MaxWr];
        int         n;
        logic [7:0] level;
        logic [7:0] diff;
        logic [7:0] opt;
        n = 0;
        if (!ready_shadow) begin
            requests_dropped++;
            return;
        end
        level = (req.brightness_level > LevelW'(LEVEL_MAX)) ? LEVEL_MAX
                                                            : req.brightness_level[7:0];
        if (!chip_on_shadow) begin
            burst[n] = '{ADDR_ENABLE, ENABLE_ON, 1'b0, 1'b0};
            n++;
            chip_on_shadow = 1'b1;
        end
        diff = (level_shadow > level) ? level_shadow - level : level - level_shadow;
        opt = req.ramp_request ? 8'(choose_step_index(5'(diff >> 3))) : 8'd0;
        burst[n] = '{ADDR_OPTIONS, opt, 1'b0, 1'b0};
        n++;
        burst[n] = '{ADDR_BRIGHT, level >> 3, 1'b0, 1'b0};
        n++;
        if (level == 8'd0) begin
            burst[n] = '{ADDR_ENABLE, ENABLE_OFF, req.ramp_request, 1'b0};
            n++;
            chip_on_shadow = 1'b0;
        end
        level_shadow = level;
        burst[n-1].last_write = 1'b1;
        for (int i = 0; i < n; i++) expected_writes.push_back(burst[i]);
    endfunction

    always @(posedge aclk) begin : request_accept
        if (aresetn && s_valid && s_ready) begin
            predict_writes(s_data);
            requests_taken++;
            s_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin : request_drive
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_requests.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        s_taken = 1'b0;
    end

    always @(posedge aclk) begin : write_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            writes_checked++;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected write: addr=%h data=%h wait=%b last=%b",
                             m_data.reg_address, m_data.reg_data,
                             m_data.wait_before, m_data.last_write);
            end else begin
                want = expected_writes.pop_front();
                if (m_data.reg_address !== want.reg_address ||
                    m_data.reg_data !== want.reg_data ||
                    m_data.wait_before !== want.wait_before ||
                    m_data.last_write !== want.last_write) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Write %0d: expected %h/%h/%b/%b, got %h/%h/%b/%b",
                                 writes_checked, want.reg_address, want.reg_data,
                                 want.wait_before, want.last_write,
                                 m_data.reg_address, m_data.reg_data,
                                 m_data.wait_before, m_data.last_write);
                end
            end
        end
    end

    always @(posedge aclk) begin : stall_timer
        if (stall_kick) begin
            stall_left <= 400;
            stall_kick = 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(negedge aclk) begin : write_accept
        if (!aresetn || stall_left != 0) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("[backlight_ramped_brightness_sequencer_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BLOCK_READY: ready_shadow = value[0];
            CFG_RAMP_TARGET: target_shadow = value[TargetW-1:0];
            CFG_STEP_TIME_0: step_shadow[0] = value[StepW-1:0];
            CFG_STEP_TIME_1: step_shadow[1] = value[StepW-1:0];
            CFG_STEP_TIME_2: step_shadow[2] = value[StepW-1:0];
            CFG_STEP_TIME_3: step_shadow[3] = value[StepW-1:0];
            default: ;
        endcase
        config_writes++;
    endtask

    task automatic configure(input logic ready, input logic [TargetW-1:0] goal,
                             input logic [StepW-1:0] t0, input logic [StepW-1:0] t1,
                             input logic [StepW-1:0] t2, input logic [StepW-1:0] t3);
        write_reg(CFG_RAMP_TARGET, CfgDatW'(goal));
        write_reg(CFG_STEP_TIME_0, CfgDatW'(t0));
        write_reg(CFG_STEP_TIME_1, CfgDatW'(t1));
        write_reg(CFG_STEP_TIME_2, CfgDatW'(t2));
        write_reg(CFG_STEP_TIME_3, CfgDatW'(t3));
        write_reg(CFG_BLOCK_READY, ready ? CfgDatW'(1) : CfgDatW'(0));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [StepW-1:0] random_step_time();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3, 4: return StepW'($urandom_range(0, 200000));
            default: return StepW'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [TargetW-1:0] goal;
        case ($urandom_range(0, 5))
            0: goal = '0;
            1: goal = '1;
            2, 3: goal = TargetW'($urandom_range(0, 4000000));
            default: goal = TargetW'($urandom);
        endcase
        configure($urandom_range(0, 7) != 0, goal, random_step_time(), random_step_time(),
                  random_step_time(), random_step_time());
    endtask

    function automatic void queue_request(logic [LevelW-1:0] level, logic ramp);
        in_t req;
        req.brightness_level = level;
        req.ramp_request = ramp;
        pending_requests.push_back(req);
    endfunction

    function automatic void queue_random_request();
        logic [LevelW-1:0] level;
        case ($urandom_range(0, 9))
            0: level = '0;
            1: level = LevelW'($urandom_range(256, 1023));
            2: level = LevelW'(LEVEL_MAX);
            default: level = LevelW'($urandom_range(0, 255));
        endcase
        queue_request(level, $urandom_range(0, 3) != 0);
    endfunction

    task automatic settle();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_writes.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : run_sequence
        send_idle_pct = 30;
        recv_idle_pct = 77;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Requests before the block is ready must be dropped silently.
        queue_request(10'd300, 1'b1);
        queue_request(10'd0, 1'b0);
        settle();

        configure(1'b1, RAMP_TARGET_RST, STEP_TIME_0_RST, STEP_TIME_1_RST,
                  STEP_TIME_2_RST, STEP_TIME_3_RST);
        queue_request(10'd1023, 1'b1);
        queue_request(10'd0, 1'b1);
        queue_request(10'd0, 1'b0);
        queue_request(10'd256, 1'b0);
        queue_request(10'd8, 1'b1);
        queue_request(10'd7, 1'b1);
        queue_request(10'd128, 1'b1);
        queue_request(10'd200, 1'b0);
        settle();

        // A zero target is met by the first step time.
        configure(1'b1, '0, STEP_TIME_0_RST, STEP_TIME_1_RST, STEP_TIME_2_RST,
                  STEP_TIME_3_RST);
        queue_request(10'd0, 1'b1);
        queue_request(10'd255, 1'b1);
        settle();

        // With the largest target no default step time reaches it.
        configure(1'b1, '1, STEP_TIME_0_RST, STEP_TIME_1_RST, STEP_TIME_2_RST,
                  STEP_TIME_3_RST);
        queue_request(10'd0, 1'b1);
        queue_request(10'd255, 1'b1);
        settle();

        configure(1'b1, '1, '1, '1, '1, '1);
        queue_request(10'd0, 1'b1);
        settle();

        configure(1'b1, 24'd1000, '0, '0, '0, '0);
        queue_request(10'd255, 1'b1);
        settle();

        // Overshoot equals shortfall here, so the higher index must win.
        configure(1'b1, 24'd6200, 20'd100, 20'd300, 20'd1000, 20'd2000);
        queue_request(10'd0, 1'b1);
        queue_request(10'd255, 1'b1);
        settle();

        configure(1'b1, 24'd500000, 20'd90000, 20'd10000, 20'd70000, 20'd5000);
        queue_request(10'd0, 1'b1);
        queue_request(10'd100, 1'b1);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES / 3) begin
                send_idle_pct = 77;
                recv_idle_pct = 30;
            end else if (p == 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config();
            repeat (PHASE_REQUESTS) queue_random_request();
            if (p == 2 * RANDOM_PHASES / 3) stall_kick = 1'b1;
            settle();
        end

        repeat (20) @(posedge aclk);
        $display("Covered %0d requests (%0d dropped while not ready) and %0d register writes.",
                 requests_taken, requests_dropped, writes_checked);
        $display("Applied %0d configuration writes; %0d mismatches found.",
                 config_writes, mismatches);
        if (mismatches == 0) begin
            $display("[backlight_ramped_brightness_sequencer_core] OK");
        end else begin
            $display("[backlight_ramped_brightness_sequencer_core] ERROR");
        end
        $finish;
    end

endmodule
